FILE: rtl/bdmfc_pkg.sv
// Shared types, constants and helpers for the border dark matte clearing block.
// No dependencies; imported by the top level.
package bdmfc_pkg;

	localparam int IDX_W     = 16;
	localparam int CRD_W     = 9;
	localparam int DIM_W     = 9;
	localparam int LIM_W     = 8;
	localparam int PIX_W     = 32;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 2;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 32;

	localparam int MAX_PIXELS = 65536;

	localparam logic [DIM_W-1:0] DEF_WIDTH  = 9'd256;
	localparam logic [DIM_W-1:0] DEF_HEIGHT = 9'd256;
	localparam logic [LIM_W-1:0] DEF_LIMIT  = 8'd48;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_LIMIT  = 2'd2
	} cfg_t;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_RUN   = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_SEED,
		ST_POP,
		ST_LOAD,
		ST_NBR,
		ST_SWEEP,
		ST_SWEEP_END,
		ST_REPLY
	} st_t;

	// Near black: visible and every colour byte at or below the limit.
	function automatic logic pix_dark(input logic [PIX_W-1:0] p, input logic [LIM_W-1:0] lim);
		pix_dark = (p[31:24] != 8'd0) && (p[7:0] <= lim) && (p[15:8] <= lim)
			&& (p[23:16] <= lim);
	endfunction

endpackage

FILE: rtl/bdmfc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bdmfc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/border_dark_matte_flood_clear_top.sv
// Border dark matte clearing: frame store, pending stack and the run sequencer.
// Depends on bdmfc_pkg and bdmfc_ram.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tuser opcode; s_tdata index, blue, green, red, alpha
//  m_*     | out | m_tvalid/m_tready  | m_tuser run_done; m_tdata blue, green, red, alpha
//  cfg_*   | in  | cfg_we             | cfg_index register, cfg_data value
//
// Write and unused items reach the output register 1 cycle after acceptance, reads 2.
// A run takes about 5 + 2*(width+height) + 7 per flooded pixel + width*height cycles:
// every step goes through the single read port of the frame store.
// Reset needs no clearing pass: a flooded pixel is zeroed at once, which also marks it.
// Input is taken again as soon as a result sits in the output register; a stalled
// output holds its beat and the next result waits in the sequencer.
module border_dark_matte_flood_clear_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [15:0] pixel_index, [23:16] in_blue, [31:24] in_green, [39:32] in_red, [47:40] in_alpha
	input  logic [bdmfc_pkg::S_TDATA_W-1:0]     s_tdata,
	// [1:0] opcode
	input  logic [bdmfc_pkg::OP_W-1:0]          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] out_blue, [15:8] out_green, [23:16] out_red, [31:24] out_alpha
	output logic [bdmfc_pkg::M_TDATA_W-1:0]     m_tdata,
	// [0] run_done
	output logic                                m_tuser,
	input  logic                                cfg_we,
	input  logic [bdmfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bdmfc_pkg::DIM_W-1:0]         cfg_data
);

	import bdmfc_pkg::*;

	localparam int AW = $clog2(MAX_PIXELS);

	st_t state_q, state_d;

	logic [DIM_W-1:0] width_q, height_q;
	logic [LIM_W-1:0] limit_q;

	logic [2*DIM_W-1:0] prod_q;
	logic [AW:0]        sp_q;
	logic [CRD_W-1:0]   cnt_q;
	logic               side_q, phase_q;
	logic [CRD_W-1:0]   cur_x_q, cur_y_q;
	logic [1:0]         nbr_q;
	logic [IDX_W-1:0]   swp_q;
	logic               rd_ok_q;

	logic               cand_v_s1;
	logic [IDX_W-1:0]   cand_idx_s1;
	logic [2*CRD_W-1:0] cand_xy_s1;
	logic               swp_v_s1;
	logic [IDX_W-1:0]   swp_idx_s1;
	logic               wr_v_q;
	logic [IDX_W-1:0]   wr_idx_q;

	logic [PIX_W-1:0]     res_pix_q;
	logic                 res_done_q;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic                 m_tuser_q;

	logic             accept;
	op_t              in_op;
	logic [IDX_W-1:0] in_idx;
	logic [PIX_W-1:0] in_pix;
	logic             in_ok;
	logic             run_ok;
	logic             seed_last;
	logic             swp_last;
	logic             out_free;

	logic               cand_v;
	logic [CRD_W-1:0]   cand_x, cand_y;
	logic [2*CRD_W:0]   cand_mul;
	logic [IDX_W-1:0]   cand_idx;
	logic [CRD_W-1:0]   w_m1, h_m1;
	logic [DIM_W-1:0]   seed_lim;

	logic             fr_re, fr_we;
	logic [IDX_W-1:0] fr_raddr, fr_waddr;
	logic [PIX_W-1:0] fr_wdata, fr_rdata;
	logic             item_wr, cand_wr, swp_wr;

	logic               st_re;
	logic [2*CRD_W-1:0] st_rdata;

	assign accept   = s_tvalid && s_tready;
	assign in_op    = op_t'(s_tuser);
	assign in_idx   = s_tdata[15:0];
	assign in_pix   = s_tdata[47:16];
	assign in_ok    = {16'd0, in_idx} < 32'(MAX_PIXELS);
	assign run_ok   = (width_q != '0) && (height_q != '0)
		&& ({14'd0, prod_q} <= 32'(MAX_PIXELS));
	assign w_m1     = CRD_W'(width_q - 9'd1);
	assign h_m1     = CRD_W'(height_q - 9'd1);
	assign seed_lim = phase_q ? height_q : width_q;
	assign seed_last = side_q && (cnt_q == seed_lim - 9'd1);
	assign swp_last = ({2'd0, swp_q} == prod_q - 18'd1);
	assign out_free = !m_tvalid_q || m_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_op)
						OP_RUN:  state_d = ST_CHECK;
						OP_READ: state_d = ST_READ;
						default: state_d = ST_REPLY;
					endcase
				end
			end
			ST_READ:  state_d = ST_REPLY;
			ST_CHECK: state_d = run_ok ? ST_SEED : ST_REPLY;
			ST_SEED: begin
				if (seed_last && phase_q) begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				if (!cand_v_s1) begin
					state_d = (sp_q == '0) ? ST_SWEEP : ST_LOAD;
				end
			end
			ST_LOAD: state_d = ST_NBR;
			ST_NBR: begin
				if (nbr_q == 2'd3) begin
					state_d = ST_POP;
				end
			end
			ST_SWEEP: begin
				if (swp_last) begin
					state_d = ST_SWEEP_END;
				end
			end
			ST_SWEEP_END: state_d = ST_REPLY;
			ST_REPLY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Candidate pixel for the darkness check: border seeds, then flood neighbors
	always_comb begin
		cand_v = 1'b0;
		cand_x = cur_x_q;
		cand_y = cur_y_q;
		if (state_q == ST_SEED) begin
			cand_v = 1'b1;
			if (!phase_q) begin
				cand_x = cnt_q;
				cand_y = side_q ? h_m1 : '0;
			end else begin
				cand_x = side_q ? w_m1 : '0;
				cand_y = cnt_q;
			end
		end else if (state_q == ST_NBR) begin
			case (nbr_q)
				2'd0: begin
					cand_v = cur_x_q != '0;
					cand_x = cur_x_q - 9'd1;
				end
				2'd1: begin
					cand_v = cur_x_q < w_m1;
					cand_x = cur_x_q + 9'd1;
				end
				2'd2: begin
					cand_v = cur_y_q != '0;
					cand_y = cur_y_q - 9'd1;
				end
				default: begin
					cand_v = cur_y_q < h_m1;
					cand_y = cur_y_q + 9'd1;
				end
			endcase
		end
		cand_mul = cand_y * width_q;
		cand_idx = IDX_W'(cand_mul + 19'(cand_x));
	end

	// Memory port control
	always_comb begin
		// a pixel zeroed at the previous edge may be read back stale: treat it as marked
		item_wr = accept && (in_op == OP_WRITE) && in_ok;
		cand_wr = cand_v_s1 && pix_dark(fr_rdata, limit_q)
			&& !(wr_v_q && (wr_idx_q == cand_idx_s1));
		swp_wr  = swp_v_s1 && (fr_rdata[31:24] == 8'd0);

		fr_re    = 1'b0;
		fr_raddr = cand_idx;
		if (accept && (in_op == OP_READ) && in_ok) begin
			fr_re    = 1'b1;
			fr_raddr = in_idx;
		end else if (cand_v) begin
			fr_re    = 1'b1;
		end else if (state_q == ST_SWEEP) begin
			fr_re    = 1'b1;
			fr_raddr = swp_q;
		end

		fr_we    = item_wr || cand_wr || swp_wr;
		fr_waddr = swp_idx_s1;
		fr_wdata = '0;
		if (item_wr) begin
			fr_waddr = in_idx;
			fr_wdata = in_pix;
		end else if (cand_wr) begin
			fr_waddr = cand_idx_s1;
		end

		st_re = (state_q == ST_POP) && !cand_v_s1 && (sp_q != '0);
	end

	bdmfc_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_PIXELS)
	) u_frame (
		.clk   (clk),
		.we    (fr_we),
		.waddr (AW'(fr_waddr)),
		.wdata (fr_wdata),
		.re    (fr_re),
		.raddr (AW'(fr_raddr)),
		.rdata (fr_rdata)
	);

	bdmfc_ram #(
		.WIDTH (2*CRD_W),
		.DEPTH (MAX_PIXELS)
	) u_stack (
		.clk   (clk),
		.we    (cand_wr),
		.waddr (sp_q[AW-1:0]),
		.wdata (cand_xy_s1),
		.re    (st_re),
		.raddr (AW'(sp_q - 1'b1)),
		.rdata (st_rdata)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			width_q    <= DEF_WIDTH;
			height_q   <= DEF_HEIGHT;
			limit_q    <= DEF_LIMIT;
			sp_q       <= '0;
			cnt_q      <= '0;
			side_q     <= 1'b0;
			phase_q    <= 1'b0;
			nbr_q      <= '0;
			swp_q      <= '0;
			cand_v_s1  <= 1'b0;
			swp_v_s1   <= 1'b0;
			wr_v_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cand_v_s1 <= cand_v;
			swp_v_s1  <= state_q == ST_SWEEP;
			wr_v_q    <= cand_wr;

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					CFG_LIMIT:  limit_q  <= cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end

			if (state_q == ST_CHECK) begin
				sp_q    <= '0;
				cnt_q   <= '0;
				side_q  <= 1'b0;
				phase_q <= 1'b0;
			end else if (cand_wr) begin
				sp_q <= sp_q + 1'b1;
			end else if (st_re) begin
				sp_q <= sp_q - 1'b1;
			end

			if (state_q == ST_SEED) begin
				side_q <= !side_q;
				if (seed_last) begin
					cnt_q   <= '0;
					phase_q <= 1'b1;
				end else if (side_q) begin
					cnt_q <= cnt_q + 9'd1;
				end
			end

			if (state_q == ST_LOAD) begin
				nbr_q <= '0;
			end else if (state_q == ST_NBR) begin
				nbr_q <= nbr_q + 2'd1;
			end

			if (state_q == ST_POP) begin
				swp_q <= '0;
			end else if (state_q == ST_SWEEP) begin
				swp_q <= swp_q + 16'd1;
			end

			// hold the beat until taken
			if (state_q == ST_REPLY && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cand_idx_s1 <= cand_idx;
		cand_xy_s1  <= {cand_y, cand_x};
		swp_idx_s1  <= swp_q;
		wr_idx_q    <= cand_idx_s1;
		if (accept) begin
			res_pix_q  <= '0;
			res_done_q <= 1'b0;
			rd_ok_q    <= in_ok;
			prod_q     <= width_q * height_q;
		end
		if (state_q == ST_READ && rd_ok_q) begin
			res_pix_q <= fr_rdata;
		end
		if (state_q == ST_SWEEP_END) begin
			res_done_q <= 1'b1;
		end
		if (state_q == ST_LOAD) begin
			{cur_y_q, cur_x_q} <= st_rdata;
		end
		if (state_q == ST_REPLY && out_free) begin
			m_tdata_q <= res_pix_q;
			m_tuser_q <= res_done_q;
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// One writer on the frame store per cycle
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({item_wr, cand_wr, swp_wr}))
		else $error("frame store written by two sources");

	// The pending stack never runs past its depth or below empty
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{{(31 - AW){1'b0}}, sp_q} <= 32'(MAX_PIXELS))
		else $error("pending stack pointer out of range");

	// Sweep starts only after the flood is fully drained
	a_sweep_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (!cand_v_s1 && (sp_q == '0)))
		else $error("sweep overlaps flood");

endmodule
